### sv/assert_macros.svh
// Assertion macros used by the pcx rle decoder controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge of clk while out of reset.
`define PCX_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition implies another in the next cycle.
`define PCX_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### sv/pcxrle_pkg.sv
// Types and constants of the pcx rle image decoder.
package pcxrle_pkg;

  localparam int unsigned HDR_LEN  = 128;
  localparam int unsigned RUN_BASE = 192;

  localparam logic [6:0] HIDX_XMIN_LO = 7'd4;
  localparam logic [6:0] HIDX_XMIN_HI = 7'd5;
  localparam logic [6:0] HIDX_YMIN_LO = 7'd6;
  localparam logic [6:0] HIDX_YMIN_HI = 7'd7;
  localparam logic [6:0] HIDX_XMAX_LO = 7'd8;
  localparam logic [6:0] HIDX_XMAX_HI = 7'd9;
  localparam logic [6:0] HIDX_YMAX_LO = 7'd10;
  localparam logic [6:0] HIDX_YMAX_HI = 7'd11;
  localparam logic [6:0] HIDX_LAST    = 7'(HDR_LEN - 1);

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_of_file;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  pixel_value;
    logic [31:0] pixel_position;
    logic        last_of_run;
    logic        image_complete;
    logic [15:0] image_width;
    logic [15:0] image_height;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic start;       // start of file seen on the accepted item
    logic hdr_take;    // accepted item is a header byte
    logic run_load;    // accepted item is a run marker
    logic emit_first;  // accepted item is a pixel byte, emit its first pixel
    logic use_run;     // pixel byte repeats by the stored run length
    logic emit_next;   // emit the next pixel of a run in progress
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic hdr_last;    // current header byte is the final one
    logic empty_img;   // xmax < xmin or ymax < ymin
    logic marker;      // input byte is a run marker
    logic run_zero;    // stored run length is zero
    logic run_one;     // stored run length is one
    logic rem_one;     // one pixel left in the run in progress
    logic complete;    // next pixel takes the count above the limit
    logic slot_free;   // output register can take a pixel this cycle
  } stat_t;

endpackage

### sv/pcxrle_chan_if.sv
// Valid/ready channel carrying one item of a given payload type.
interface pcxrle_chan_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### sv/pcxrle_dp.sv
// Datapath: header capture, image limit, run counters and output register.
module pcxrle_dp (
  input  logic                  clk,
  input  logic                  rst_n,
  input  pcxrle_pkg::in_item_t  in_item,
  input  pcxrle_pkg::cmd_t      cmd,
  output pcxrle_pkg::stat_t     st,
  output logic                  out_valid,
  input  logic                  out_ready,
  output pcxrle_pkg::out_item_t out_item
);

  logic [6:0]  hcnt_r, hcnt_nxt, hidx;
  logic [15:0] xmin_r, ymin_r, xmax_r, ymax_r;
  logic [15:0] xmin_nxt, ymin_nxt, xmax_nxt, ymax_nxt;
  logic [15:0] w_r, h_r;
  logic [31:0] limit_r;
  logic [5:0]  run_len_r, run_len_nxt;
  logic [5:0]  remain_r, remain_nxt;
  logic [7:0]  byte_r, byte_nxt;
  logic [31:0] cnt_r, cnt_nxt, cnt_inc;
  logic        out_valid_r, out_valid_nxt;
  pcxrle_pkg::out_item_t out_r, out_nxt;
  logic        emit, last_now;

  assign hidx    = cmd.start ? 7'd0 : hcnt_r;
  assign cnt_inc = (cnt_r == '1) ? cnt_r : cnt_r + 32'd1;
  assign emit    = cmd.emit_first || cmd.emit_next;

  always_comb begin
    st.hdr_last  = (hidx == pcxrle_pkg::HIDX_LAST);
    st.empty_img = (xmax_r < xmin_r) || (ymax_r < ymin_r);
    st.marker    = (in_item.data_byte >= 8'(pcxrle_pkg::RUN_BASE));
    st.run_zero  = (run_len_r == 6'd0);
    st.run_one   = (run_len_r == 6'd1);
    st.rem_one   = (remain_r == 6'd1);
    st.complete  = (cnt_inc > limit_r);
    st.slot_free = !out_valid_r || out_ready;
  end

  // header capture
  always_comb begin
    hcnt_nxt = hcnt_r;
    xmin_nxt = xmin_r;
    ymin_nxt = ymin_r;
    xmax_nxt = xmax_r;
    ymax_nxt = ymax_r;
    if (cmd.hdr_take) begin
      hcnt_nxt = st.hdr_last ? 7'd0 : hidx + 7'd1;
      case (hidx)
        pcxrle_pkg::HIDX_XMIN_LO: xmin_nxt[7:0]  = in_item.data_byte;
        pcxrle_pkg::HIDX_XMIN_HI: xmin_nxt[15:8] = in_item.data_byte;
        pcxrle_pkg::HIDX_YMIN_LO: ymin_nxt[7:0]  = in_item.data_byte;
        pcxrle_pkg::HIDX_YMIN_HI: ymin_nxt[15:8] = in_item.data_byte;
        pcxrle_pkg::HIDX_XMAX_LO: xmax_nxt[7:0]  = in_item.data_byte;
        pcxrle_pkg::HIDX_XMAX_HI: xmax_nxt[15:8] = in_item.data_byte;
        pcxrle_pkg::HIDX_YMAX_LO: ymax_nxt[7:0]  = in_item.data_byte;
        pcxrle_pkg::HIDX_YMAX_HI: ymax_nxt[15:8] = in_item.data_byte;
        default: ;
      endcase
    end
  end

  // run counters, pixel count and output register
  always_comb begin
    run_len_nxt   = run_len_r;
    remain_nxt    = remain_r;
    byte_nxt      = byte_r;
    cnt_nxt       = cnt_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    last_now      = 1'b0;

    if (cmd.hdr_take && st.hdr_last) begin
      cnt_nxt     = 32'd0;
      run_len_nxt = 6'd0;
    end
    if (cmd.run_load) begin
      run_len_nxt = 6'(in_item.data_byte - 8'(pcxrle_pkg::RUN_BASE));
    end

    if (cmd.emit_first) begin
      byte_nxt   = in_item.data_byte;
      remain_nxt = cmd.use_run ? run_len_r - 6'd1 : 6'd0;
      last_now   = cmd.use_run ? st.run_one : 1'b1;
    end else if (cmd.emit_next) begin
      remain_nxt = remain_r - 6'd1;
      last_now   = st.rem_one;
    end

    if (emit) begin
      out_valid_nxt          = 1'b1;
      out_nxt.pixel_value    = cmd.emit_first ? in_item.data_byte : byte_r;
      out_nxt.pixel_position = cnt_r;
      out_nxt.last_of_run    = last_now;
      out_nxt.image_complete = last_now && st.complete;
      out_nxt.image_width    = w_r;
      out_nxt.image_height   = h_r;
      cnt_nxt                = cnt_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hcnt_r      <= 7'd0;
      xmin_r      <= 16'd0;
      ymin_r      <= 16'd0;
      xmax_r      <= 16'd0;
      ymax_r      <= 16'd0;
      run_len_r   <= 6'd0;
      remain_r    <= 6'd0;
      cnt_r       <= 32'd0;
      out_valid_r <= 1'b0;
    end else begin
      hcnt_r      <= hcnt_nxt;
      xmin_r      <= xmin_nxt;
      ymin_r      <= ymin_nxt;
      xmax_r      <= xmax_nxt;
      ymax_r      <= ymax_nxt;
      run_len_r   <= run_len_nxt;
      remain_r    <= remain_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // spans are registered from the coordinate registers, the limit from the registered spans
  always_ff @(posedge clk) begin
    w_r     <= (xmax_r >= xmin_r) ? xmax_r - xmin_r : 16'd0;
    h_r     <= (ymax_r >= ymin_r) ? ymax_r - ymin_r : 16'd0;
    limit_r <= 32'(w_r) * 32'(h_r);
    byte_r  <= byte_nxt;
    out_r   <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

### sv/pcxrle_ctrl.sv
// Controller: decode phase, pending run marker and run drain sequencing.
`include "assert_macros.svh"

module pcxrle_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              sof,
  output logic              in_ready,
  input  pcxrle_pkg::stat_t st,
  output pcxrle_pkg::cmd_t  cmd
);

  typedef enum logic [1:0] {PH_HEADER, PH_BODY, PH_DONE} phase_t;
  typedef enum logic {M_IDLE, M_DRAIN} mode_t;

  phase_t phase_r, phase_nxt, phase_eff;
  mode_t  mode_r, mode_nxt;
  logic   pend_r, pend_nxt, pend_eff;
  logic   acc;
  logic   done_keep;

  assign in_ready  = (mode_r == M_IDLE) && st.slot_free;
  assign acc       = in_valid && in_ready;
  assign phase_eff = sof ? PH_HEADER : phase_r;
  assign pend_eff  = sof ? 1'b0 : pend_r;

  // stay in done unless a start of file is taken
  assign done_keep = (phase_r == PH_DONE) && !(acc && sof);

  always_comb begin
    cmd       = '0;
    phase_nxt = phase_r;
    mode_nxt  = mode_r;
    pend_nxt  = pend_r;
    case (mode_r)
      M_IDLE: begin
        if (acc) begin
          cmd.start = sof;
          if (sof) begin
            phase_nxt = PH_HEADER;
            pend_nxt  = 1'b0;
          end
          case (phase_eff)
            PH_HEADER: begin
              cmd.hdr_take = 1'b1;
              if (st.hdr_last) begin
                phase_nxt = st.empty_img ? PH_DONE : PH_BODY;
                pend_nxt  = 1'b0;
              end
            end
            PH_BODY: begin
              if (pend_eff) begin
                pend_nxt = 1'b0;
                if (!st.run_zero) begin
                  cmd.emit_first = 1'b1;
                  cmd.use_run    = 1'b1;
                  if (st.run_one) begin
                    if (st.complete) phase_nxt = PH_DONE;
                  end else begin
                    mode_nxt = M_DRAIN;
                  end
                end
              end else if (st.marker) begin
                cmd.run_load = 1'b1;
                pend_nxt     = 1'b1;
              end else begin
                cmd.emit_first = 1'b1;
                if (st.complete) phase_nxt = PH_DONE;
              end
            end
            default: ;
          endcase
        end
      end
      M_DRAIN: begin
        if (st.slot_free) begin
          cmd.emit_next = 1'b1;
          if (st.rem_one) begin
            mode_nxt = M_IDLE;
            if (st.complete) phase_nxt = PH_DONE;
          end
        end
      end
      default: mode_nxt = M_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEADER;
      mode_r  <= M_IDLE;
      pend_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      mode_r  <= mode_nxt;
      pend_r  <= pend_nxt;
    end
  end

  `PCX_ASSERT_NEXT(a_done_holds, done_keep, phase_r == PH_DONE, "done phase left early")
  `PCX_ASSERT(a_no_drain_in_header, (phase_r == PH_HEADER) |-> (mode_r == M_IDLE), "header drain")
  `PCX_ASSERT(a_drain_no_pending, (mode_r == M_DRAIN) |-> !pend_r, "marker pending in drain")

endmodule

### sv/pcx_rle_image_decoder_unit.sv
// PCX rle image decoder, 8-bit pixels: one file byte in, zero to 63 pixels out per byte.
//
// The block takes a PCX file one byte per input item. A byte with start_of_file set
// restarts the decoder and counts as header byte 0. Of the 128 header bytes it keeps
// the little-endian words xmin, ymin, xmax and ymax; width and height are the
// differences (0 when negative) and the pixel limit is width times height. The body is
// run-length decoded: a byte of 193..255 makes a run of (byte - 192) copies of the next
// byte, 192 makes an empty run, any other byte is one literal pixel. Decoding stops at
// the end of the item whose pixels take the count above the limit (a started run always
// completes, and that final pixel carries image_complete); a negative span skips the
// body entirely. Bytes after that are dropped until the next start of file.
// Flow: header bytes, run markers, dropped bytes and literals never start a drain; the
// data byte of a run of n > 1 pixels holds the input while the run drains, as the single
// output register issues one pixel per cycle when not stalled. Both sides may stall freely;
// input is taken when no run drains and the output register is free or being emptied.
module pcx_rle_image_decoder_unit (
  input  logic          clk,
  input  logic          rst_n,
  pcxrle_chan_if.sink   in_if,
  pcxrle_chan_if.source out_if
);

  pcxrle_pkg::cmd_t  cmd;
  pcxrle_pkg::stat_t st;

  // sequencing: phase, pending marker, drain of multi-pixel runs
  pcxrle_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .sof      (in_if.data.start_of_file),
    .in_ready (in_if.ready),
    .st       (st),
    .cmd      (cmd)
  );

  // header fields, limit, counters and the output register
  pcxrle_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_if.data),
    .cmd       (cmd),
    .st        (st),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .out_item  (out_if.data)
  );

endmodule

### verif/pcx_rle_image_decoder_unit_tb.sv
// Self-checking testbench of the PCX rle image decoder: directed table, then random files.
module pcx_rle_image_decoder_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Decoder phases as the predictor tracks them.
  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_BODY   = 2'd1,
    PH_DONE   = 2'd2
  } dec_phase_e;

  // A directed row is either a whole header (expanded to its bytes) or one file byte.
  typedef enum logic {
    ROW_HDR  = 1'b0,
    ROW_BYTE = 1'b1
  } row_kind_e;

  typedef struct packed {
    row_kind_e   kind;
    logic        sof;
    logic        typed;     // the expected outcome below is filled in
    logic [7:0]  b;
    logic [15:0] x0;
    logic [15:0] y0;
    logic [15:0] x1;
    logic [15:0] y1;
    logic [6:0]  exp_n;     // pixels caused by this byte
    logic [7:0]  exp_pos;   // position of the first of them
    logic        exp_done;  // image_complete on the last of them
  } stim_row_t;

  logic clk;
  logic rst_n;

  pcxrle_chan_if #(.T(pcxrle_pkg::in_item_t))  in_ch ();
  pcxrle_chan_if #(.T(pcxrle_pkg::out_item_t)) out_ch ();

  pcx_rle_image_decoder_unit i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  // Directed part: header capture without a start mark, literal extremes, the empty run,
  // a marker byte as run data, completion, the negative span, zero width and height, the
  // longest runs, the largest image, and restarts after a bare marker and during the body.
  stim_row_t directed_rows [25] = '{
    '{ROW_HDR,  1'b0, 1'b0, 8'h00, 16'h0000, 16'h0000, 16'h0003, 16'h0002, 7'd0,  8'd0, 1'b0},
    '{ROW_BYTE, 1'b0, 1'b1, 8'h00, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 7'd1,  8'd0, 1'b0},
    '{ROW_BYTE, 1'b0, 1'b1, 8'hBF, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 7'd1,  8'd1, 1'b0},
    '{ROW_BYTE, 1'b0, 1'b1, 8'hC0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 7'd0,  8'd0, 1'b0},
    '{ROW_BYTE, 1'b0, 1'b1, 8'h55, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 7'd0,  8'd0, 1'b0},
    '{ROW_BYTE, 1'b0, 1'b1, 8'hC1, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 7'd0,  8'd0, 1'b0},
    '{ROW_BYTE, 1'b0, 1'b1, 8'hFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 7'd1,  8'd2, 1'b0},
    '{ROW_BYTE, 1'b0, 1'b1, 8'hC3, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 7'd0,  8'd0, 1'b0},
    '{ROW_BYTE, 1'b0, 1'b1, 8'hC0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 7'd3,  8'd3, 1'b0},
    '{ROW_BYTE, 1'b0, 1'b1, 8'h07, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 7'd1,  8'd6, 1'b1},
    '{ROW_BYTE, 1'b0, 1'b1, 8'h33, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 7'd0,  8'd0, 1'b0},
    '{ROW_HDR,  1'b1, 1'b0, 8'h00, 16'h0005, 16'h0000, 16'h0004, 16'h0009, 7'd0,  8'd0, 1'b0},
    '{ROW_BYTE, 1'b0, 1'b1, 8'h12, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 7'd0,  8'd0, 1'b0},
    '{ROW_HDR,  1'b1, 1'b0, 8'h00, 16'h1234, 16'hFFFF, 16'h1234, 16'hFFFF, 7'd0,  8'd0, 1'b0},
    '{ROW_BYTE, 1'b0, 1'b1, 8'hFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 7'd0,  8'd0, 1'b0},
    '{ROW_BYTE, 1'b0, 1'b1, 8'hA5, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 7'd63, 8'd0, 1'b1},
    '{ROW_HDR,  1'b1, 1'b0, 8'h00, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 7'd0,  8'd0, 1'b0},
    '{ROW_BYTE, 1'b0, 1'b1, 8'hFE, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 7'd0,  8'd0, 1'b0},
    '{ROW_BYTE, 1'b0, 1'b1, 8'h80, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 7'd62, 8'd0, 1'b0},
    '{ROW_BYTE, 1'b0, 1'b0, 8'hC5, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 7'd0,  8'd0, 1'b0},
    '{ROW_HDR,  1'b1, 1'b0, 8'h00, 16'h0001, 16'h0001, 16'h0002, 16'h0002, 7'd0,  8'd0, 1'b0},
    '{ROW_BYTE, 1'b0, 1'b1, 8'h01, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 7'd1,  8'd0, 1'b0},
    '{ROW_HDR,  1'b1, 1'b0, 8'h00, 16'h0000, 16'h0000, 16'h0001, 16'h0001, 7'd0,  8'd0, 1'b0},
    '{ROW_BYTE, 1'b0, 1'b0, 8'hC2, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 7'd0,  8'd0, 1'b0},
    '{ROW_BYTE, 1'b0, 1'b1, 8'h44, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 7'd2,  8'd0, 1'b1}
  };

  // Predictor state: a private copy of what the decoder remembers between bytes.
  dec_phase_e  dec_phase;
  logic [6:0]  hdr_pos;
  logic [15:0] xmin_w, ymin_w, xmax_w, ymax_w;
  logic        run_armed;
  logic [5:0]  run_len;
  logic [31:0] px_count;

  // Pixels predicted and not yet seen on the output, oldest first.
  pcxrle_pkg::out_item_t expected_pixels [$];

  int mismatches     = 0;
  int pixels_checked = 0;
  int files_sent     = 0;
  int body_bytes     = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_kicks     = 0;

  // Free-running clock, 10 ns period.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Print one line per mismatch, but keep the log short on a broken design.
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    if (mismatches <= 40)
      $display("%0t mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
  endtask

  function automatic void clear_decoder();
    dec_phase = PH_HEADER;
    hdr_pos   = '0;
    xmin_w    = '0;
    ymin_w    = '0;
    xmax_w    = '0;
    ymax_w    = '0;
    run_armed = 1'b0;
    run_len   = '0;
    px_count  = '0;
  endfunction

  // Advance the predictor by one accepted file byte and queue the pixels it yields.
  function automatic void decode_byte(input logic [7:0] b, input logic sof,
                                      output int n_px, output logic done_px);
    logic [31:0]           w, h, lim;
    pcxrle_pkg::out_item_t px;
    n_px    = 0;
    done_px = 1'b0;
    if (sof) clear_decoder();

    if (dec_phase == PH_HEADER) begin
      case (hdr_pos)
        pcxrle_pkg::HIDX_XMIN_LO: xmin_w[7:0]  = b;
        pcxrle_pkg::HIDX_XMIN_HI: xmin_w[15:8] = b;
        pcxrle_pkg::HIDX_YMIN_LO: ymin_w[7:0]  = b;
        pcxrle_pkg::HIDX_YMIN_HI: ymin_w[15:8] = b;
        pcxrle_pkg::HIDX_XMAX_LO: xmax_w[7:0]  = b;
        pcxrle_pkg::HIDX_XMAX_HI: xmax_w[15:8] = b;
        pcxrle_pkg::HIDX_YMAX_LO: ymax_w[7:0]  = b;
        pcxrle_pkg::HIDX_YMAX_HI: ymax_w[15:8] = b;
        default: ;
      endcase
      if (hdr_pos == pcxrle_pkg::HIDX_LAST) begin
        hdr_pos   = '0;
        px_count  = '0;
        run_armed = 1'b0;
        run_len   = '0;
        // a negative span skips the body altogether
        dec_phase = (xmax_w < xmin_w || ymax_w < ymin_w) ? PH_DONE : PH_BODY;
      end else begin
        hdr_pos = hdr_pos + 7'd1;
      end
      return;
    end
    if (dec_phase != PH_BODY) return;

    if (run_armed) begin
      n_px      = int'(run_len);
      run_armed = 1'b0;
    end else if (b >= pcxrle_pkg::RUN_BASE) begin
      run_len   = 6'(b - pcxrle_pkg::RUN_BASE);
      run_armed = 1'b1;
      return;
    end else begin
      n_px = 1;
    end

    w   = (xmax_w >= xmin_w) ? {16'd0, xmax_w - xmin_w} : 32'd0;
    h   = (ymax_w >= ymin_w) ? {16'd0, ymax_w - ymin_w} : 32'd0;
    lim = w * h;

    for (int k = 0; k < n_px; k++) begin
      px.pixel_value    = b;
      px.pixel_position = px_count;
      px.last_of_run    = (k == n_px - 1);
      px.image_width    = w[15:0];
      px.image_height   = h[15:0];
      if (px_count != '1) px_count = px_count + 32'd1;
      // completion is judged on the count after the whole byte
      px.image_complete = (k == n_px - 1) && (px_count > lim);
      expected_pixels.push_back(px);
    end

    done_px = (px_count > lim);
    if (done_px) dec_phase = PH_DONE;
  endfunction

  // Offer one byte from a falling edge, hold it until taken, return at a falling edge.
  task automatic send_byte(input logic [7:0] b, input logic sof, output int n_px,
                           output logic done_px, output logic [31:0] first_pos);
    while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= {b, sof};
    do @(posedge clk); while (!in_ch.ready);
    decode_byte(b, sof, n_px, done_px);
    first_pos = (n_px > 0) ?
                expected_pixels[expected_pixels.size() - n_px].pixel_position : 32'd0;
    @(negedge clk);
  endtask

  // Send the first nbytes of a header; bytes outside the corner words are filler.
  task automatic send_header(input logic sof, input logic [15:0] x0, input logic [15:0] y0,
                             input logic [15:0] x1, input logic [15:0] y1, input int nbytes);
    logic [7:0]  b;
    int          n;
    logic        d;
    logic [31:0] fp;
    for (int i = 0; i < nbytes; i++) begin
      case (7'(i))
        pcxrle_pkg::HIDX_XMIN_LO: b = x0[7:0];
        pcxrle_pkg::HIDX_XMIN_HI: b = x0[15:8];
        pcxrle_pkg::HIDX_YMIN_LO: b = y0[7:0];
        pcxrle_pkg::HIDX_YMIN_HI: b = y0[15:8];
        pcxrle_pkg::HIDX_XMAX_LO: b = x1[7:0];
        pcxrle_pkg::HIDX_XMAX_HI: b = x1[15:8];
        pcxrle_pkg::HIDX_YMAX_LO: b = y1[7:0];
        pcxrle_pkg::HIDX_YMAX_HI: b = y1[15:8];
        default:                  b = 8'($urandom_range(0, 255));
      endcase
      send_byte(b, sof && (i == 0), n, d, fp);
    end
  endtask

  // Drop valid, then hold the sender until every predicted pixel has come out.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (expected_pixels.size() != 0) @(negedge clk);
  endtask

  // One random file: mostly well-formed bodies of small images, with some large and
  // empty images, restarts inside a header, and bodies cut off after a bare marker.
  task automatic send_random_file(input bit pressure);
    logic [15:0] x0, y0, x1, y1;
    int          pick, budget, sent, len;
    int          n;
    logic        d;
    logic [31:0] fp;
    bit          cut;
    pick = $urandom_range(0, 99);
    if (pressure || pick < 10) begin
      x0 = 16'($urandom_range(0, 15));
      y0 = 16'($urandom_range(0, 15));
      x1 = 16'($urandom_range(16'hF000, 16'hFFFF));
      y1 = 16'($urandom_range(16'hF000, 16'hFFFF));
    end else if (pick < 22) begin
      x0 = 16'($urandom_range(1, 65535));
      y0 = 16'($urandom_range(1, 65535));
      x1 = 16'($urandom_range(0, x0 - 1));
      y1 = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, y0 - 1)) :
           16'($urandom_range(y0, 65535));
      if ($urandom_range(0, 1) == 0) begin
        // let only the height go negative this time
        x1 = 16'($urandom_range(x0, 65535));
        y1 = 16'($urandom_range(0, y0 - 1));
      end
    end else begin
      x0 = 16'($urandom_range(0, 65527));
      y0 = 16'($urandom_range(0, 65527));
      x1 = x0 + 16'($urandom_range(0, 7));
      y1 = y0 + 16'($urandom_range(0, 7));
    end

    // Abort a header partway; the next start mark must restart the count.
    if (!pressure && $urandom_range(0, 11) == 0)
      send_header(1'b1, y0, x0, y1, x1, $urandom_range(1, 127));
    send_header(1'b1, x0, y0, x1, y1, pcxrle_pkg::HDR_LEN);
    files_sent++;

    if (pressure) begin
      // Stall the output while a full run drains, so the input backs up.
      hold_kicks++;
      send_byte(8'hFF, 1'b0, n, d, fp);
      send_byte(8'($urandom_range(0, 255)), 1'b0, n, d, fp);
      body_bytes += 2;
    end

    budget = $urandom_range(4, 40);
    sent   = 0;
    cut    = 1'b0;
    while (dec_phase == PH_BODY && sent < budget && !cut) begin
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        send_byte(8'($urandom_range(0, pcxrle_pkg::RUN_BASE - 1)), 1'b0, n, d, fp);
        sent++;
      end else if (pick < 95) begin
        // pick < 88: real run; otherwise the empty run
        len = (pick >= 88) ? 0 :
              ($urandom_range(0, 1) == 0) ? $urandom_range(1, 4) : $urandom_range(1, 63);
        send_byte(8'(pcxrle_pkg::RUN_BASE + len), 1'b0, n, d, fp);
        send_byte(8'($urandom_range(0, 255)), 1'b0, n, d, fp);
        sent += 2;
      end else begin
        // leave a marker hanging; the next start mark drops it
        send_byte(8'($urandom_range(pcxrle_pkg::RUN_BASE, 255)), 1'b0, n, d, fp);
        sent++;
        cut = 1'b1;
      end
    end
    body_bytes += sent;

    // Trailing bytes after completion are dropped by the block.
    if (dec_phase == PH_DONE)
      repeat ($urandom_range(0, 3)) send_byte(8'($urandom_range(0, 255)), 1'b0, n, d, fp);
  endtask

  // Receiver: random stalls, plus a long hold-off whenever the stimulus asks for one.
  initial begin
    int kicks_seen;
    int hold_left;
    kicks_seen   = 0;
    hold_left    = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_kicks != kicks_seen) begin
        kicks_seen = hold_kicks;
        hold_left  = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  // Compare every pixel taken from the block with the oldest prediction.
  always @(posedge clk) begin : check_pixels
    pcxrle_pkg::out_item_t got;
    pcxrle_pkg::out_item_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = out_ch.data;
      pixels_checked++;
      if (expected_pixels.size() == 0) begin
        report_mismatch("pixel with none expected", got.pixel_position, 32'd0);
      end else begin
        want = expected_pixels.pop_front();
        if (got.pixel_value != want.pixel_value)
          report_mismatch("pixel_value", 32'(got.pixel_value), 32'(want.pixel_value));
        if (got.pixel_position != want.pixel_position)
          report_mismatch("pixel_position", got.pixel_position, want.pixel_position);
        if (got.last_of_run != want.last_of_run)
          report_mismatch("last_of_run", 32'(got.last_of_run), 32'(want.last_of_run));
        if (got.image_complete != want.image_complete)
          report_mismatch("image_complete", 32'(got.image_complete),
                          32'(want.image_complete));
        if (got.image_width != want.image_width)
          report_mismatch("image_width", 32'(got.image_width), 32'(want.image_width));
        if (got.image_height != want.image_height)
          report_mismatch("image_height", 32'(got.image_height), 32'(want.image_height));
      end
    end
  end

  // Stimulus: reset, directed table, then four idling phases of random files.
  initial begin
    stim_row_t   row;
    int          n;
    logic        d;
    logic [31:0] fp;
    int          ph;
    int          cur_ph;
    bit          pressure_now;

    rst_n       = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data  = '0;
    clear_decoder();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.kind == ROW_HDR) begin
        send_header(row.sof, row.x0, row.y0, row.x1, row.y1, pcxrle_pkg::HDR_LEN);
      end else begin
        send_byte(row.b, row.sof, n, d, fp);
        if (row.typed) begin
          if (n != int'(row.exp_n))
            report_mismatch("directed pixel count", 32'(n), 32'(row.exp_n));
          if (n > 0 && fp != {24'd0, row.exp_pos})
            report_mismatch("directed first position", fp, 32'(row.exp_pos));
          if (d != row.exp_done)
            report_mismatch("directed completion", 32'(d), 32'(row.exp_done));
        end
      end
    end

    cur_ph       = -1;
    pressure_now = 1'b0;
    while (body_bytes < 230) begin
      ph = body_bytes * 4 / 230;
      if (ph != cur_ph) begin
        // drain before switching the idling pattern
        wait_drained();
        cur_ph = ph;
        case (ph)
          0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
          1:       begin send_idle_pct = 61; recv_stall_pct = 0;  end
          2:       begin send_idle_pct = 0;  recv_stall_pct = 61; end
          default: begin send_idle_pct = 10; recv_stall_pct = 10; end
        endcase
        pressure_now = (ph == 2);
      end
      send_random_file(pressure_now);
      pressure_now = 1'b0;
    end

    wait_drained();
    // allow for any stray pixel still in flight
    repeat (100) @(posedge clk);

    $display("run covered %0d random files, %0d random body bytes, %0d pixels checked",
             files_sent, body_bytes, pixels_checked);
    $display("mismatches: %0d", mismatches);
    if (mismatches == 0 && expected_pixels.size() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("timeout with %0d pixels outstanding", expected_pixels.size());
    $display("FAIL");
    $finish;
  end

endmodule
